// File: hw/rtl/bqd_pkg.sv
// ---------------------------------------------------------------------------
// bqd_pkg
// Widths, codes and helper functions for the direct form II biquad core.
// ---------------------------------------------------------------------------
package bqd_pkg;

  localparam int CHANNELS       = 8;
  localparam int CHAN_BITS      = 3;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 18;
  localparam int COEF_FRAC_BITS = 16;
  localparam int DELAY_BITS     = 32;
  localparam int PROD_BITS      = COEF_BITS + DELAY_BITS;
  localparam int ACC_BITS       = PROD_BITS + 4;
  localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;

  localparam logic signed [COEF_BITS-1:0] COEF_B0_RST = COEF_BITS'(65536);

  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

  function automatic logic signed [DELAY_BITS-1:0] sat_dly(
    input logic signed [SHIFT_BITS-1:0] v
  );
    logic [SHIFT_BITS-DELAY_BITS:0] hi;
    hi = v[SHIFT_BITS-1:DELAY_BITS-1];
    if ((&hi) || !(|hi)) begin
      return v[DELAY_BITS-1:0];
    end else if (v[SHIFT_BITS-1]) begin
      return {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [SHIFT_BITS-1:0] v
  );
    logic [SHIFT_BITS-SAMPLE_BITS:0] hi;
    hi = v[SHIFT_BITS-1:SAMPLE_BITS-1];
    if ((&hi) || !(|hi)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SHIFT_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// File: hw/rtl/bqd_if.sv
// ---------------------------------------------------------------------------
// bqd_if
// Valid/ready channels of the biquad core: sample in, sample out, config.
// ---------------------------------------------------------------------------
interface bqd_in_if import bqd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [CHAN_BITS-1:0]          channel_in;

  modport source (output valid, output sample_in, output channel_in, input ready);
  modport sink   (input valid, input sample_in, input channel_in, output ready);
endinterface

interface bqd_out_if import bqd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CHAN_BITS-1:0]          channel_out;

  modport source (output valid, output sample_out, output channel_out, input ready);
  modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

interface bqd_cfg_if import bqd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [2:0]                  index;
  logic signed [COEF_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bqd_mac.sv
// ---------------------------------------------------------------------------
// bqd_mac
// Shared 18x32 multiplier with registered product and accumulator.
// ---------------------------------------------------------------------------
module bqd_mac import bqd_pkg::*; (
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [DELAY_BITS-1:0]  data,
  input  logic signed [ACC_BITS-1:0]    load_val,
  output logic signed [ACC_BITS-1:0]    sum
);

  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [ACC_BITS-1:0]  prod_ext;

  assign prod_ext = ACC_BITS'(prod_r);
  assign sum      = ctrl.sub ? (acc_r - prod_ext) : (acc_r + prod_ext);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * data;
    end
    if (ctrl.acc_load) begin
      acc_r <= load_val;
    end else if (ctrl.acc_en) begin
      acc_r <= sum;
    end
  end

endmodule

// File: hw/rtl/biquad_direct_form_two_filter_core.sv
// ---------------------------------------------------------------------------
// biquad_direct_form_two_filter_core
// Eight-channel direct form II biquad with saturating 32-bit delay state.
// Sequence: an accepted word steps through A1, A2, W, B0, B1, B2 and Y;
// the result is registered in Y once the output is free. A new word is taken
// only in IDLE. The five products share one 18x32 multiplier, one per step.
// Reset: coefficients to pass-through (b0 = 1.0), all delay state zeroed.
// ---------------------------------------------------------------------------
module biquad_direct_form_two_filter_core import bqd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  bqd_in_if.sink   in_if,
  bqd_out_if.source out_if,
  bqd_cfg_if.sink  cfg_if
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_A1, ST_A2, ST_W, ST_B0, ST_B1, ST_B2, ST_Y
  } state_t;

  state_t                        state_r;
  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [DELAY_BITS-1:0]  delay_one_r [CHANNELS];
  logic signed [DELAY_BITS-1:0]  delay_two_r [CHANNELS];
  logic signed [DELAY_BITS-1:0]  w1_r, w2_r, w_r;
  logic [CHAN_BITS-1:0]          chan_r;
  logic                          chan_ok_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHAN_BITS-1:0]          out_chan_r;

  mac_ctrl_t                     ctrl;
  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [DELAY_BITS-1:0]  data_op;
  logic signed [ACC_BITS-1:0]    load_val;
  logic signed [ACC_BITS-1:0]    sum;
  logic                          in_take;
  logic                          out_free;

  assign in_if.ready       = (state_r == ST_IDLE);
  assign in_take           = in_if.valid && in_if.ready;
  assign out_free          = !out_valid_r || out_if.ready;
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.channel_out = out_chan_r;

  always_comb begin
    ctrl     = '0;
    coef_op  = '0;
    data_op  = '0;
    load_val = ROUND_HALF;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.acc_load = in_take;
        load_val = (ACC_BITS'(in_if.sample_in) <<< COEF_FRAC_BITS) + ROUND_HALF;
      end
      ST_A1: begin
        ctrl.mul_en = 1'b1;
        coef_op = a1_r;
        data_op = w1_r;
      end
      ST_A2: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_en = 1'b1;
        ctrl.sub    = 1'b1;
        coef_op = a2_r;
        data_op = w2_r;
      end
      ST_W: begin
        ctrl.sub      = 1'b1;
        ctrl.acc_load = 1'b1;
      end
      ST_B0: begin
        ctrl.mul_en = 1'b1;
        coef_op = b0_r;
        data_op = w_r;
      end
      ST_B1: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_en = 1'b1;
        coef_op = b1_r;
        data_op = w1_r;
      end
      ST_B2: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_en = 1'b1;
        coef_op = b2_r;
        data_op = w2_r;
      end
      ST_Y: begin
      end
      default: begin
      end
    endcase
  end

  bqd_mac u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .coef     (coef_op),
    .data     (data_op),
    .load_val (load_val),
    .sum      (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      b0_r        <= COEF_B0_RST;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        delay_one_r[i] <= '0;
        delay_two_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_if.ready && (state_r != ST_Y)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_idx_t'(cfg_if.index))
          CFG_B0:  b0_r <= cfg_if.data;
          CFG_B1:  b1_r <= cfg_if.data;
          CFG_B2:  b2_r <= cfg_if.data;
          CFG_A1:  a1_r <= cfg_if.data;
          CFG_A2:  a2_r <= cfg_if.data;
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            chan_r    <= in_if.channel_in;
            chan_ok_r <= (32'(in_if.channel_in) < CHANNELS);
            w1_r      <= delay_one_r[in_if.channel_in];
            w2_r      <= delay_two_r[in_if.channel_in];
            state_r   <= ST_A1;
          end
        end
        ST_A1: state_r <= ST_A2;
        ST_A2: state_r <= ST_W;
        ST_W: begin
          w_r     <= sat_dly(sum[ACC_BITS-1:COEF_FRAC_BITS]);
          state_r <= ST_B0;
        end
        ST_B0: state_r <= ST_B1;
        ST_B1: state_r <= ST_B2;
        ST_B2: state_r <= ST_Y;
        ST_Y: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_chan_r  <= chan_r;
            if (chan_ok_r) begin
              out_sample_r        <= sat_smp(sum[ACC_BITS-1:COEF_FRAC_BITS]);
              delay_one_r[chan_r] <= w_r;
              delay_two_r[chan_r] <= w1_r;
            end else begin
              out_sample_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/tb_biquad_direct_form_two_filter_core.sv
// ---------------------------------------------------------------------------
// tb_biquad_direct_form_two_filter_core
// Self-checking bench for the eight-channel direct form II biquad. A table of
// directed words (pass-through after reset, rail samples, rail coefficients,
// delay saturation) runs first. Random phases follow, each with its own
// coefficient set. Every accepted sample word is run through a bit-exact
// predictor, and each output word is checked against the oldest prediction.
// The sender bursts, the receiver stalls on a pattern, and once it holds off
// long enough to back the core up.
// ---------------------------------------------------------------------------
module tb_biquad_direct_form_two_filter_core;
  import bqd_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 500;
  localparam int N_PHASES     = 10;
  localparam int N_SETS       = 5;
  localparam int PHASE_WORDS  = 175;
  localparam int N_DIR        = 37;

  localparam logic signed [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_B0_RST;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_ZERO = '0;

  // indexes past the last coefficient decode to nothing
  localparam logic [2:0] CFG_IDX_SPARE = 3'(CFG_A2) + 3'd1;
  localparam logic [2:0] CFG_IDX_TOP   = 3'b111;

  typedef enum bit {ROW_SAMPLE, ROW_COEF} row_kind_t;

  typedef enum int {SET_WILD, SET_RAIL, SET_STABLE, SET_FIR, SET_MIXED} coef_set_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CHAN_BITS-1:0]          channel_out;
  } filt_word_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [2:0]                    idx;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [CHAN_BITS-1:0]          ch;
    bit                            typed;
    logic signed [SAMPLE_BITS-1:0] y_typed;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // pass-through after reset
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_ZERO,      3'd0, 1'b1, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd1, 1'b1, SMP_MAX},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd2, 1'b1, SMP_MIN},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, -24'sd1,       3'd3, 1'b1, -24'sd1},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, 24'sd1,        3'd4, 1'b1, 24'sd1},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, 24'sh555555,   3'd5, 1'b1, 24'sh555555},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, 24'shAAAAAA,   3'd6, 1'b1, 24'shAAAAAA},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd7, 1'b1, SMP_MAX},
    // gain near +2 and -2: output saturates
    '{ROW_COEF,   CFG_B0, COEF_MAX,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd0, 1'b1, SMP_MAX},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd1, 1'b1, SMP_MIN},
    '{ROW_COEF,   CFG_B0, COEF_MIN,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd2, 1'b1, SMP_MIN},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd3, 1'b1, SMP_MAX},
    // runaway feedback: delay state hits the 32-bit rail
    '{ROW_COEF,   CFG_B0, COEF_ONE,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_B1, COEF_MAX,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_B2, COEF_MIN,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_A1, COEF_MIN,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_A2, COEF_MIN,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd4, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, 24'sh123456,   3'd5, 1'b0, SMP_ZERO},
    // write to an unused index must leave the coefficients alone
    '{ROW_COEF,   CFG_IDX_SPARE, COEF_MAX, SMP_ZERO, 3'd0, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, -24'sd1000,    3'd5, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_A1, COEF_ZERO, SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_COEF,   CFG_A2, COEF_MAX,  SMP_ZERO,      3'd0, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MIN,       3'd6, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_MAX,       3'd6, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, CFG_B0, COEF_ZERO, SMP_ZERO,      3'd6, 1'b0, SMP_ZERO}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bqd_in_if  in_ch ();
  bqd_out_if out_ch ();
  bqd_cfg_if cfg_ch ();

  biquad_direct_form_two_filter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter state mirror
  logic signed [COEF_BITS-1:0]  k_b0, k_b1, k_b2, k_a1, k_a2;
  logic signed [DELAY_BITS-1:0] w1_hist [CHANNELS];
  logic signed [DELAY_BITS-1:0] w2_hist [CHANNELS];

  filt_word_t pending_words [$];
  int         mismatch_count = 0;
  int         results_count  = 0;
  int         burst_left     = 0;
  int         idle_cycles    = 0;

  function automatic void reset_filter();
    k_b0 = COEF_B0_RST;
    k_b1 = '0;
    k_b2 = '0;
    k_a1 = '0;
    k_a2 = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      w1_hist[i] = '0;
      w2_hist[i] = '0;
    end
  endfunction

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up, then floor shift
  function automatic longint round_q(input longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function automatic filt_word_t filter_step(input logic signed [SAMPLE_BITS-1:0] smp,
                                             input logic [CHAN_BITS-1:0] ch);
    filt_word_t r;
    longint     x, d1, d2, acc, w, y;
    x   = smp;
    d1  = w1_hist[ch];
    d2  = w2_hist[ch];
    acc = x * (longint'(1) <<< COEF_FRAC_BITS) - longint'(k_a1) * d1 - longint'(k_a2) * d2;
    w   = clamp_bits(round_q(acc), DELAY_BITS);
    acc = longint'(k_b0) * w + longint'(k_b1) * d1 + longint'(k_b2) * d2;
    y   = clamp_bits(round_q(acc), SAMPLE_BITS);
    w2_hist[ch]   = w1_hist[ch];
    w1_hist[ch]   = DELAY_BITS'(w);
    r.sample_out  = SAMPLE_BITS'(y);
    r.channel_out = ch;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SMP_ZERO;
      3: begin
        v = int'($urandom_range(0, 510)) - 255;
        return SAMPLE_BITS'(v);
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] pick_coef(input coef_set_t kind);
    if (kind == SET_WILD) return COEF_BITS'($urandom);
    if (kind == SET_RAIL) return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
    case ($urandom_range(0, 3))
      0: return COEF_ZERO;
      1: return COEF_MAX;
      2: return COEF_MIN;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  // all tasks start and end at a falling edge
  task automatic write_coef(input logic [2:0] idx, input logic signed [COEF_BITS-1:0] val,
                            input bit more);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_B0:  k_b0 = val;
      CFG_B1:  k_b1 = val;
      CFG_B2:  k_b2 = val;
      CFG_A1:  k_a1 = val;
      CFG_A2:  k_a2 = val;
      default: ;
    endcase
    @(negedge clk);
    if (!more) cfg_ch.valid = 1'b0;
  endtask

  task automatic feed_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic [CHAN_BITS-1:0] ch,
                             input bit typed,
                             input logic signed [SAMPLE_BITS-1:0] y_typed);
    filt_word_t want;
    int         gap;
    in_ch.valid      = 1'b1;
    in_ch.sample_in  = smp;
    in_ch.channel_in = ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = filter_step(smp, ch);
    if (typed) want.sample_out = y_typed;
    pending_words.push_back(want);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15));
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 200))
                                               : int'($urandom_range(0, 15));
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain_pipe();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_coef_set(input coef_set_t kind);
    logic signed [COEF_BITS-1:0] cb0, cb1, cb2, ca1, ca2;
    int                          a2v, lim;
    cb0 = pick_coef(kind);
    cb1 = pick_coef(kind);
    cb2 = pick_coef(kind);
    ca1 = pick_coef(kind);
    ca2 = pick_coef(kind);
    if (kind == SET_STABLE) begin
      a2v = int'($urandom_range(0, 58000));
      lim = (65536 + a2v) * 9 / 10;
      ca2 = COEF_BITS'(a2v);
      ca1 = COEF_BITS'(int'($urandom_range(0, 2 * lim)) - lim);
      cb0 = COEF_BITS'(int'($urandom_range(0, 16384)) - 8192);
      cb1 = COEF_BITS'(int'($urandom_range(0, 16384)) - 8192);
      cb2 = COEF_BITS'(int'($urandom_range(0, 16384)) - 8192);
    end else if (kind == SET_FIR) begin
      ca1 = COEF_ZERO;
      ca2 = COEF_ZERO;
      cb0 = COEF_BITS'(int'($urandom_range(0, 131072)) - 65536);
      cb1 = COEF_BITS'(int'($urandom_range(0, 131072)) - 65536);
      cb2 = COEF_BITS'(int'($urandom_range(0, 131072)) - 65536);
    end
    if ($urandom_range(0, 1)) begin
      write_coef(3'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)), COEF_BITS'($urandom), 1'b1);
    end
    write_coef(CFG_B0, cb0, 1'b1);
    write_coef(CFG_B1, cb1, 1'b1);
    write_coef(CFG_B2, cb2, 1'b1);
    write_coef(CFG_A1, ca1, 1'b1);
    write_coef(CFG_A2, ca2, 1'b0);
  endtask

  // output word checker
  always @(posedge clk) begin : word_check
    filt_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_count++;
      if (pending_words.size() == 0) begin
        $error("unexpected output word: sample_out %0d channel_out %0d",
               out_ch.sample_out, out_ch.channel_out);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_ch.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_ch.sample_out);
          mismatch_count++;
        end
        if (out_ch.channel_out !== want.channel_out) begin
          $error("channel_out: expected %0d, got %0d", want.channel_out, out_ch.channel_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no handshake for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: ready follows a 16-bit stall pattern redrawn at random, one long hold-off
  initial begin : sink_side
    int          cyc;
    logic [15:0] pat;
    bit          held;
    cyc  = 0;
    pat  = '1;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '1;
          1: pat = 16'($urandom);
          2: pat = 16'($urandom & $urandom & $urandom);
          default: pat = 16'($urandom | $urandom);
        endcase
      end
      out_ch.ready = pat[cyc % 16];
      cyc++;
    end
  end

  initial begin : source_side
    int       r, ph;
    bit       more;
    dir_row_t row;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    in_ch.channel_in = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_B0;
    cfg_ch.data      = '0;
    reset_filter();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (r = 0; r < N_DIR; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_COEF) begin
        if (r == 0 || DIR_ROWS[r-1].kind != ROW_COEF) drain_pipe();
        more = (r + 1 < N_DIR) && (DIR_ROWS[r+1].kind == ROW_COEF);
        write_coef(row.idx, row.coef, more);
      end else begin
        feed_sample(row.smp, row.ch, row.typed, row.y_typed);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_pipe();
      load_coef_set(coef_set_t'(ph % N_SETS));
      repeat (PHASE_WORDS) begin
        feed_sample(pick_sample(), CHAN_BITS'($urandom_range(0, CHANNELS - 1)), 1'b0, SMP_ZERO);
      end
    end

    drain_pipe();
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
